[src/sfp_pkg.sv]
// ----------------------------------------------------------------------------
// sfp_pkg: frame packer constants and channel scaling
// shared byte codes, code limits and the value-to-code scaling function
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam int unsigned ValueWidth  = 16;
  localparam int unsigned CodeWidth   = 11;
  localparam int unsigned NumChannels = 16;
  localparam int unsigned ChanWidth   = $clog2(NumChannels);

  localparam logic [7:0] HEADER_BYTE = 8'h0F;
  localparam logic [7:0] FLAGS_BYTE  = 8'h00;
  localparam logic [7:0] END_BYTE    = 8'h00;

  localparam logic [CodeWidth-1:0] CENTER_CODE = 11'd992;
  localparam logic [CodeWidth-1:0] MAX_CODE    = 11'd2047;

  // beyond this magnitude the code is pinned at a rail
  localparam logic [16:0] MAG_LIMIT = 17'd700;
  // x / 5 == (x * 52429) >> 18 for x below 2^16
  localparam logic [15:0] RECIP_5 = 16'd52429;

  typedef logic [7:0] byte_t;

  // (v * 8) / 5 truncated toward zero, plus center, clamped to 0..2047
  function automatic logic [CodeWidth-1:0] scale_code(input logic signed [ValueWidth-1:0] v);
    logic        neg;
    logic [16:0] mag;
    logic [12:0] mag8;
    logic [28:0] prod;
    logic [10:0] quo;
    logic [11:0] sum;
    logic [CodeWidth-1:0] code;
    neg  = v[ValueWidth-1];
    mag  = neg ? (17'd0 - {v[ValueWidth-1], v}) : {1'b0, v};
    mag8 = {mag[9:0], 3'b000};
    prod = {16'd0, mag8} * {13'd0, RECIP_5};
    quo  = prod[28:18];
    sum  = {1'b0, CENTER_CODE} + {1'b0, quo};
    if (mag > MAG_LIMIT) begin
      code = neg ? '0 : MAX_CODE;
    end else if (neg) begin
      code = (quo > CENTER_CODE) ? '0 : (CENTER_CODE - quo);
    end else begin
      code = sum[11] ? MAX_CODE : sum[CodeWidth-1:0];
    end
    return code;
  endfunction

endpackage

[src/sbus_frame_packer_core.sv]
// ----------------------------------------------------------------------------
// sbus_frame_packer_core: 16-channel serial bus frame packer
// turns signed channel words into the 25-byte frame, one byte per output word
// ----------------------------------------------------------------------------
// Each accepted channel word produces one to four bytes: the header byte ahead
// of channel 0, one or two packed data bytes, and the flags and end bytes after
// channel 15 (frame_end marks the end byte). A channel word lands in an input
// register and is scaled and packed combinationally as the load moves it into
// a four-byte output queue; the queue then presents one byte per cycle while
// out_ready is high. The input register takes the next channel word while the
// queue is still draining, so with out_ready held high a full frame of 16 words
// streams out as 25 bytes. The first byte of a word passes through the input
// register and then the output queue before it leaves on the port.
// Sustained throughput is set by the byte-wide output port.
module sbus_frame_packer_core
  import sfp_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ValueWidth-1:0] channel_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   frame_byte,
  output logic                         frame_end
);

  // input register
  logic                         in_full;
  logic signed [ValueWidth-1:0] in_value;

  // packing state: leftover bits (always fewer than 8) and channel position
  logic [6:0]           acc;
  logic [2:0]           held;
  logic [ChanWidth-1:0] chan;

  // output queue, entry 0 is on the port
  byte_t      obyte [4];
  logic [3:0] oend;
  logic [2:0] ocount;

  logic load;
  logic out_take;

  assign out_valid  = (ocount != 3'd0);
  assign out_take   = out_valid && out_ready;
  assign frame_byte = obyte[0];
  assign frame_end  = oend[0];

  // refill the queue when it is empty or its last byte leaves now
  assign load     = in_full && ((ocount == 3'd0) || ((ocount == 3'd1) && out_ready));
  assign in_ready = !in_full || load;

  // ---- scale and pack ----
  logic [CodeWidth-1:0] code;
  logic                 first_ch;
  logic                 last_ch;
  logic [6:0]           acc_in;
  logic [2:0]           held_in;
  logic [17:0]          packed_bits;
  logic [4:0]           total_bits;
  logic                 two_bytes;
  logic [6:0]           acc_next;
  logic [2:0]           held_next;
  byte_t                q_byte [4];
  logic [3:0]           q_end;
  logic [2:0]           q_count;
  logic [1:0]           pos_data;
  logic [1:0]           pos_flags;

  always_comb begin
    code       = scale_code(in_value);
    first_ch   = (chan == '0);
    last_ch    = (chan == ChanWidth'(NumChannels - 1));
    // a new frame starts from an empty accumulator
    acc_in     = first_ch ? 7'd0 : acc;
    held_in    = first_ch ? 3'd0 : held;
    packed_bits = {11'd0, acc_in} | ({7'd0, code} << held_in);
    total_bits = {2'b00, held_in} + 5'd11;
    two_bytes  = (total_bits >= 5'd16);
    if (last_ch) begin
      // 176 bits fill 22 bytes exactly, nothing carries over
      acc_next  = '0;
      held_next = '0;
    end else if (two_bytes) begin
      acc_next  = {5'd0, packed_bits[17:16]};
      held_next = total_bits[2:0];
    end else begin
      acc_next  = packed_bits[14:8];
      held_next = total_bits[2:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      q_byte[i] = '0;
    end
    q_end     = '0;
    pos_data  = {1'b0, first_ch};
    pos_flags = pos_data + 2'd1 + {1'b0, two_bytes};
    if (first_ch) begin
      q_byte[0] = HEADER_BYTE;
    end
    q_byte[pos_data] = packed_bits[7:0];
    if (two_bytes) begin
      q_byte[pos_data + 2'd1] = packed_bits[15:8];
    end
    if (last_ch) begin
      q_byte[pos_flags]        = FLAGS_BYTE;
      q_byte[pos_flags + 2'd1] = END_BYTE;
      q_end[pos_flags + 2'd1]  = 1'b1;
    end
    q_count = 3'd1 + {2'b00, first_ch} + {2'b00, two_bytes} + {1'b0, last_ch, 1'b0};
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      ocount  <= '0;
      acc     <= '0;
      held    <= '0;
      chan    <= '0;
    end else begin
      if (in_ready) begin
        in_full <= in_valid;
      end
      if (load) begin
        ocount <= q_count;
        acc    <= acc_next;
        held   <= held_next;
        chan   <= chan + ChanWidth'(1);
      end else if (out_take) begin
        ocount <= ocount - 3'd1;
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_value <= channel_value;
    end
    if (load) begin
      for (int i = 0; i < 4; i++) begin
        obyte[i] <= q_byte[i];
      end
      oend <= q_end;
    end else if (out_take) begin
      for (int i = 0; i < 3; i++) begin
        obyte[i] <= obyte[i+1];
      end
      obyte[3] <= '0;
      oend     <= {1'b0, oend[3:1]};
    end
  end

  // ---- assertions ----
  // queue never holds more than one channel's worth of bytes
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    ocount <= 3'd4)
    else $error("output queue count out of range");

  // the end mark only ever rides on the end byte
  a_end_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> frame_byte == END_BYTE)
    else $error("frame_end on a byte other than the end byte");

  // after the last channel the accumulator is empty for the next frame
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    load && (chan == ChanWidth'(NumChannels - 1)) |=> chan == '0 && held == '0 && acc == '0)
    else $error("packing state not cleared at frame wrap");

  // a load always leaves bytes to send
  a_load_fill: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("queue empty after a load");

endmodule
